[hw/rtl/swik_pkg.sv]
// Shared constants, types and the arctangent table of the swerve kinematics unit.
package swik_pkg;

  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned LANE_STAGES   = CORDIC_STAGES + 6;
  localparam int unsigned PIPE_STAGES   = LANE_STAGES + 1;

  localparam int unsigned VEL_W   = 16;
  localparam int unsigned ANG_W   = 17;
  localparam int unsigned SPD_W   = 24;
  localparam int unsigned REG_W   = 16;
  localparam int unsigned PROD_W  = 33;
  localparam int unsigned XW      = 36;
  localparam int unsigned ZW      = 28;
  localparam int unsigned ATAN_W  = 25;
  localparam int unsigned GAIN_W  = 30;
  localparam int unsigned DIFF_W  = 18;

  localparam logic [GAIN_W-1:0] GAIN_COMP   = 30'd652032874;
  localparam logic [ZW-1:0]     Z_HALF_PI   = 28'd26353589;
  localparam logic [DIFF_W-1:0] ANG_PI      = 18'd25736;
  localparam logic [DIFF_W-1:0] ANG_HALF_PI = 18'd12868;
  localparam logic [DIFF_W-1:0] ANG_TWO_PI  = 18'd51472;
  localparam logic [SPD_W-1:0]  SPEED_MAX   = 24'd8388607;

  typedef enum logic [1:0] {
    CFG_WHEEL_BASE  = 2'd0,
    CFG_WHEEL_TRACK = 2'd1,
    CFG_INV_RADIUS  = 2'd2
  } cfg_idx_e;

  // atan(2^-i) in Q.24 radians, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_q24(input logic [4:0] idx);
    logic [ATAN_W-1:0] r;
    unique case (idx)
      5'd0:  r = 25'd13176795;
      5'd1:  r = 25'd7778716;
      5'd2:  r = 25'd4110060;
      5'd3:  r = 25'd2086331;
      5'd4:  r = 25'd1047214;
      5'd5:  r = 25'd524117;
      5'd6:  r = 25'd262123;
      5'd7:  r = 25'd131069;
      5'd8:  r = 25'd65536;
      5'd9:  r = 25'd32768;
      5'd10: r = 25'd16384;
      5'd11: r = 25'd8192;
      5'd12: r = 25'd4096;
      5'd13: r = 25'd2048;
      5'd14: r = 25'd1024;
      5'd15: r = 25'd512;
      5'd16: r = 25'd256;
      5'd17: r = 25'd128;
      5'd18: r = 25'd64;
      5'd19: r = 25'd32;
      5'd20: r = 25'd16;
      5'd21: r = 25'd8;
      5'd22: r = 25'd4;
      5'd23: r = 25'd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/swerve_inverse_kinematics_unit.sv]
// Top level: four-wheel swerve drive inverse kinematics, stream in and out.
// Throughput: one transaction per cycle unless the output is stalled; four wheel lanes run side by side,
// each with one register per CORDIC iteration.
// Reset: rst_ni (async, low) clears all valid bits and restores the chassis
// registers to base 8192, track 8192, inverse radius 5120. No clearing pass.
module swerve_inverse_kinematics_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  // vel_x[15:0], vel_y[31:16], yaw_rate[47:32], current_front_left[64:48],
  // current_front_right[81:65], current_rear_left[98:82],
  // current_rear_right[115:99], zero fill [119:116]
  input  logic [119:0]  s_axis_tdata,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // speed_front_left[23:0], speed_front_right[47:24], speed_rear_left[71:48],
  // speed_rear_right[95:72], steer_front_left[112:96],
  // steer_front_right[129:113], steer_rear_left[146:130],
  // steer_rear_right[163:147], zero fill [167:164]
  output logic [167:0]  m_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);
  localparam int unsigned N  = swik_pkg::PIPE_STAGES;
  localparam int unsigned VW = swik_pkg::VEL_W;
  localparam int unsigned AW = swik_pkg::ANG_W;
  localparam int unsigned SW = swik_pkg::SPD_W;

  // Chassis geometry registers; software must write them only while idle (not enforced here).
  logic [swik_pkg::REG_W-1:0] base_q, track_q, inv_r_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= 16'd8192;
      track_q <= 16'd8192;
      inv_r_q <= 16'd5120;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        swik_pkg::CFG_WHEEL_BASE:  base_q  <= cfg_data_i;
        swik_pkg::CFG_WHEEL_TRACK: track_q <= cfg_data_i;
        swik_pkg::CFG_INV_RADIUS:  inv_r_q <= cfg_data_i;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // Valid bit per stage. A stage loads when it is empty or its successor
  // loads, so bubbles collapse and the front keeps accepting while a
  // finished result waits at the output, until every stage is full.
  logic [N-1:0] v_q, en;

  assign en[N-1] = !v_q[N-1] || m_axis_tready;
  for (genvar k = 0; k < N - 1; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[N-1];

  // Stage 0: unpack, form yaw rate times half track and half base.
  logic signed [VW-1:0] vx_q, vy_q;
  logic signed [swik_pkg::PROD_W-1:0] pw_q, pl_q;
  logic signed [AW-1:0] cur_q [4];
  logic signed [VW-1:0] yaw;

  assign yaw = $signed(s_axis_tdata[47:32]);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      vx_q     <= $signed(s_axis_tdata[15:0]);
      vy_q     <= $signed(s_axis_tdata[31:16]);
      pw_q     <= swik_pkg::PROD_W'(yaw) * $signed({17'b0, track_q});
      pl_q     <= swik_pkg::PROD_W'(yaw) * $signed({17'b0, base_q});
      cur_q[0] <= $signed(s_axis_tdata[64:48]);
      cur_q[1] <= $signed(s_axis_tdata[81:65]);
      cur_q[2] <= $signed(s_axis_tdata[98:82]);
      cur_q[3] <= $signed(s_axis_tdata[115:99]);
    end
  end

  // Lanes: left front, right front, left rear, right rear.
  logic signed [SW-1:0] speed [4];
  logic signed [AW-1:0] steer [4];

  for (genvar w = 0; w < 4; w++) begin : g_wheel
    swik_wheel u_wheel (
      .clk_i   (clk_i),
      .en_i    (en[N-1:1]),
      .rear_i  (w >= 2),
      .right_i (w == 1 || w == 3),
      .vx_i    (vx_q),
      .vy_i    (vy_q),
      .pw_i    (pw_q),
      .pl_i    (pl_q),
      .cur_i   (cur_q[w]),
      .inv_r_i (inv_r_q),
      .speed_o (speed[w]),
      .steer_o (steer[w])
    );
  end

  assign m_axis_tdata = {4'b0, steer[3], steer[2], steer[1], steer[0],
                         speed[3], speed[2], speed[1], speed[0]};

endmodule

[hw/rtl/swik_wheel.sv]
// One wheel lane: vector build, pipelined CORDIC, speed scaling and flip.
module swik_wheel (
  input  logic                                   clk_i,
  input  logic [swik_pkg::LANE_STAGES-1:0]       en_i,
  input  logic                                   rear_i,
  input  logic                                   right_i,
  input  logic signed [swik_pkg::VEL_W-1:0]      vx_i,
  input  logic signed [swik_pkg::VEL_W-1:0]      vy_i,
  input  logic signed [swik_pkg::PROD_W-1:0]     pw_i,
  input  logic signed [swik_pkg::PROD_W-1:0]     pl_i,
  input  logic signed [swik_pkg::ANG_W-1:0]      cur_i,
  input  logic [swik_pkg::REG_W-1:0]             inv_r_i,
  output logic signed [swik_pkg::SPD_W-1:0]      speed_o,
  output logic signed [swik_pkg::ANG_W-1:0]      steer_o
);
  localparam int unsigned CS = swik_pkg::CORDIC_STAGES;
  localparam int unsigned XW = swik_pkg::XW;
  localparam int unsigned ZW = swik_pkg::ZW;
  localparam int unsigned DW = swik_pkg::DIFF_W;

  logic signed [XW-1:0] x_q [CS+1];
  logic signed [XW-1:0] y_q [CS+1];
  logic signed [ZW-1:0] z_q [CS+1];
  logic signed [swik_pkg::ANG_W-1:0] cur_q [CS+1];
  logic zf_q [CS+1];

  // vector build and quadrant pre-rotation
  logic signed [XW-1:0] cx, cy;
  always_comb begin
    cx = (XW'(vx_i) <<< 15) - (right_i ? -XW'(pw_i) : XW'(pw_i));
    cy = (XW'(vy_i) <<< 15) + (rear_i  ? -XW'(pl_i) : XW'(pl_i));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cur_q[0] <= cur_i;
      zf_q[0]  <= (cx == '0) && (cy == '0);
      if (cx < 0) begin
        if (cy >= 0) begin
          x_q[0] <= cy;
          y_q[0] <= -cx;
          z_q[0] <= $signed(swik_pkg::Z_HALF_PI);
        end else begin
          x_q[0] <= -cy;
          y_q[0] <= cx;
          z_q[0] <= -$signed(swik_pkg::Z_HALF_PI);
        end
      end else begin
        x_q[0] <= cx;
        y_q[0] <= cy;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar gi = 0; gi < CS; gi++) begin : g_cordic
    logic signed [ZW-1:0] atan_s;
    assign atan_s = $signed(ZW'(swik_pkg::atan_q24(5'(gi))));
    always_ff @(posedge clk_i) begin
      if (en_i[1+gi]) begin
        cur_q[gi+1] <= cur_q[gi];
        zf_q[gi+1]  <= zf_q[gi];
        if (!y_q[gi][XW-1]) begin
          x_q[gi+1] <= x_q[gi] + (y_q[gi] >>> gi);
          y_q[gi+1] <= y_q[gi] - (x_q[gi] >>> gi);
          z_q[gi+1] <= z_q[gi] + atan_s;
        end else begin
          x_q[gi+1] <= x_q[gi] - (y_q[gi] >>> gi);
          y_q[gi+1] <= y_q[gi] + (x_q[gi] >>> gi);
          z_q[gi+1] <= z_q[gi] - atan_s;
        end
      end
    end
  end

  // gain compensation split into two partial products
  logic [46:0] ph_q, pl_q;
  logic signed [swik_pkg::ANG_W-1:0] ang1_q, cur1_q;
  logic signed [ZW-1:0] zr;
  assign zr = z_q[CS] + ZW'(1024);

  always_ff @(posedge clk_i) begin
    if (en_i[CS+1]) begin
      ph_q   <= 47'(x_q[CS][33:17]) * 47'(swik_pkg::GAIN_COMP);
      pl_q   <= 47'(x_q[CS][16:0]) * 47'(swik_pkg::GAIN_COMP);
      ang1_q <= zf_q[CS] ? '0 : zr[27:11];
      cur1_q <= cur_q[CS];
    end
  end

  logic [63:0] mag_sum;
  logic [33:0] mag_q;
  logic signed [DW-1:0] diff2_q;
  logic signed [swik_pkg::ANG_W-1:0] ang2_q;
  assign mag_sum = {ph_q, 17'b0} + 64'(pl_q);

  always_ff @(posedge clk_i) begin
    if (en_i[CS+2]) begin
      mag_q   <= mag_sum[63:30];
      diff2_q <= DW'(ang1_q) - DW'(cur1_q);
      ang2_q  <= ang1_q;
    end
  end

  // wrap the difference into [-pi, pi]
  logic signed [DW-1:0] w1, w2, w3, w4;
  always_comb begin
    w1 = (diff2_q > $signed(swik_pkg::ANG_PI)) ? diff2_q - $signed(swik_pkg::ANG_TWO_PI)
                                               : diff2_q;
    w2 = (w1 > $signed(swik_pkg::ANG_PI)) ? w1 - $signed(swik_pkg::ANG_TWO_PI) : w1;
    w3 = (w2 < -$signed(swik_pkg::ANG_PI)) ? w2 + $signed(swik_pkg::ANG_TWO_PI) : w2;
    w4 = (w3 < -$signed(swik_pkg::ANG_PI)) ? w3 + $signed(swik_pkg::ANG_TWO_PI) : w3;
  end

  logic [49:0] prod_q;
  logic signed [DW-1:0] diff3_q;
  logic signed [swik_pkg::ANG_W-1:0] ang3_q;
  always_ff @(posedge clk_i) begin
    if (en_i[CS+3]) begin
      prod_q  <= 50'(mag_q) * 50'(inv_r_i);
      diff3_q <= w4;
      ang3_q  <= ang2_q;
    end
  end

  logic [50:0] rnd;
  logic [swik_pkg::SPD_W-1:0] spd_raw;
  assign rnd     = 51'(prod_q) + (51'(1) << 26);
  assign spd_raw = rnd[50:27];

  logic [swik_pkg::SPD_W-1:0] spd4_q;
  logic flip4_q, pos4_q;
  logic signed [swik_pkg::ANG_W-1:0] ang4_q;
  always_ff @(posedge clk_i) begin
    if (en_i[CS+4]) begin
      spd4_q  <= spd_raw[swik_pkg::SPD_W-1] ? swik_pkg::SPEED_MAX : spd_raw;
      flip4_q <= (diff3_q > $signed(swik_pkg::ANG_HALF_PI)) ||
                 (diff3_q < -$signed(swik_pkg::ANG_HALF_PI));
      pos4_q  <= diff3_q > 0;
      ang4_q  <= ang3_q;
    end
  end

  logic signed [swik_pkg::ANG_W-1:0] pi_a;
  assign pi_a = $signed(swik_pkg::ANG_PI[swik_pkg::ANG_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (en_i[CS+5]) begin
      speed_o <= flip4_q ? -$signed(spd4_q) : $signed(spd4_q);
      if (!flip4_q)    steer_o <= ang4_q;
      else if (pos4_q) steer_o <= ang4_q - pi_a;
      else             steer_o <= ang4_q + pi_a;
    end
  end

endmodule

[hw/rtl/swik_checker.sv]
// Port-level checker for the swerve kinematics unit, bound to the top level.
module swik_sva (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          s_axis_tready,
  input logic [167:0]  m_axis_tdata,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic          cfg_ready_o
);

  // an empty output means the whole pipeline can move
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped under stall");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed under stall");

  // speeds saturate symmetrically, so the most negative code never shows
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:0] != 24'h800000 &&
                      m_axis_tdata[47:24] != 24'h800000 &&
                      m_axis_tdata[71:48] != 24'h800000 &&
                      m_axis_tdata[95:72] != 24'h800000)
    else $error("speed outside saturation range");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind swerve_inverse_kinematics_unit swik_sva u_swik_sva (.*);
